[hdl/pdc_pkg.sv]
// Shared constants, register codes and types for the PID distance controller.
// No dependencies; every other file but pdc_if refers to this package by scoped names.
package pdc_pkg;

  // Defaults for top-level parameters
  localparam int DIST_BITS_DEF = 13;
  localparam int DRIVE_MAX_DEF = 255;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RATE      = 3'd7;

  // Field widths of the fixed-format registers
  localparam int GAIN_W   = 32;
  localparam int ALPHA_W  = 17;
  localparam int PERIOD_W = 24;
  localparam int RATE_W   = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // Reset values
  localparam int RST_SETPOINT  = 100;
  localparam int RST_THRESHOLD = 30;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_P = 32'sd73385;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_I = 32'sd141682;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_D = 32'sd37306499;
  localparam logic [ALPHA_W-1:0]  RST_ALPHA  = 17'd65536;
  localparam logic [PERIOD_W-1:0] RST_PERIOD = 24'd167772;
  localparam logic [RATE_W-1:0]   RST_RATE   = 16'd100;

  // Controller state width (Q24.16, saturating)
  localparam int ACC_W = 40;

  // Serial multiplier geometry
  localparam int MUL_A_W   = 40;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = 6;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [ALPHA_W-1:0]       alpha;
    logic [PERIOD_W-1:0]      period;
    logic [RATE_W-1:0]        rate;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic                 b_signed;
    logic [MUL_CNT_W-1:0] nbits;
  } mul_req_t;

endpackage

[hdl/pdc_if.sv]
// Valid/ready channel interfaces for distance samples and drive results.
// Standalone; widths are set by the instantiating level.
interface pdc_in_if #(
  parameter int DIST_W = 13
);
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

interface pdc_out_if #(
  parameter int DRIVE_W = 9
);
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      safety_stop;
  logic                      saturated;

  modport source (output valid, output drive, output safety_stop, output saturated,
                  input ready);
  modport sink   (input valid, input drive, input safety_stop, input saturated,
                  output ready);
endinterface

[hdl/pdc_cfg_regs.sv]
// APB-style register file for setpoint, threshold, gains and timing.
// Depends on pdc_pkg for register codes, widths and reset values.
module pdc_cfg_regs #(
  parameter int DIST_BITS = pdc_pkg::DIST_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pdc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pdc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic [DIST_BITS-1:0]            setpoint_o,
  output logic [DIST_BITS-1:0]            threshold_o,
  output pdc_pkg::cfg_t                   cfg_o
);

  logic [DIST_BITS-1:0]          setpoint_q, threshold_q;
  pdc_pkg::cfg_t                 cfg_q;
  logic                          wr;
  logic [pdc_pkg::REG_IDX_W-1:0] idx;
  logic [pdc_pkg::ALPHA_W-1:0]   alpha_in;

  assign wr       = psel & penable & pwrite;
  assign idx      = paddr[pdc_pkg::CFG_ADDR_W-1:2];
  assign alpha_in = pwdata[pdc_pkg::ALPHA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= DIST_BITS'(pdc_pkg::RST_SETPOINT);
      threshold_q  <= DIST_BITS'(pdc_pkg::RST_THRESHOLD);
      cfg_q.gain_p <= pdc_pkg::RST_GAIN_P;
      cfg_q.gain_i <= pdc_pkg::RST_GAIN_I;
      cfg_q.gain_d <= pdc_pkg::RST_GAIN_D;
      cfg_q.alpha  <= pdc_pkg::RST_ALPHA;
      cfg_q.period <= pdc_pkg::RST_PERIOD;
      cfg_q.rate   <= pdc_pkg::RST_RATE;
    end else if (wr) begin
      case (idx)
        pdc_pkg::REG_SETPOINT:  setpoint_q   <= pwdata[DIST_BITS-1:0];
        pdc_pkg::REG_THRESHOLD: threshold_q  <= pwdata[DIST_BITS-1:0];
        pdc_pkg::REG_GAIN_P:    cfg_q.gain_p <= pwdata[pdc_pkg::GAIN_W-1:0];
        pdc_pkg::REG_GAIN_I:    cfg_q.gain_i <= pwdata[pdc_pkg::GAIN_W-1:0];
        pdc_pkg::REG_GAIN_D:    cfg_q.gain_d <= pwdata[pdc_pkg::GAIN_W-1:0];
        pdc_pkg::REG_ALPHA: begin
          // weights above one saturate to one
          cfg_q.alpha <= (alpha_in > pdc_pkg::ALPHA_ONE) ? pdc_pkg::ALPHA_ONE : alpha_in;
        end
        pdc_pkg::REG_PERIOD:    cfg_q.period <= pwdata[pdc_pkg::PERIOD_W-1:0];
        pdc_pkg::REG_RATE:      cfg_q.rate   <= pwdata[pdc_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pdc_pkg::REG_SETPOINT:  prdata = pdc_pkg::CFG_DATA_W'(setpoint_q);
      pdc_pkg::REG_THRESHOLD: prdata = pdc_pkg::CFG_DATA_W'(threshold_q);
      pdc_pkg::REG_GAIN_P:    prdata = cfg_q.gain_p;
      pdc_pkg::REG_GAIN_I:    prdata = cfg_q.gain_i;
      pdc_pkg::REG_GAIN_D:    prdata = cfg_q.gain_d;
      pdc_pkg::REG_ALPHA:     prdata = pdc_pkg::CFG_DATA_W'(cfg_q.alpha);
      pdc_pkg::REG_PERIOD:    prdata = pdc_pkg::CFG_DATA_W'(cfg_q.period);
      pdc_pkg::REG_RATE:      prdata = pdc_pkg::CFG_DATA_W'(cfg_q.rate);
      default:                prdata = '0;
    endcase
  end

  assign setpoint_o  = setpoint_q;
  assign threshold_o = threshold_q;
  assign cfg_o       = cfg_q;

endmodule

[hdl/pdc_serial_mul.sv]
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
// Depends on pdc_pkg for operand widths and the request struct.
module pdc_serial_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pdc_pkg::mul_req_t                   req_i,
  input  logic signed [pdc_pkg::MUL_A_W-1:0]  a_i,
  input  logic [pdc_pkg::MUL_B_W-1:0]         b_i,
  output logic                                done_o,
  output logic signed [pdc_pkg::MUL_P_W-1:0]  p_o
);

  logic                                busy_q;
  logic [pdc_pkg::MUL_CNT_W-1:0]       cnt_q;
  logic                                bsig_q;
  logic signed [pdc_pkg::MUL_P_W-1:0]  a_sh_q, acc_q;
  logic [pdc_pkg::MUL_B_W-1:0]         b_sh_q;
  logic signed [pdc_pkg::MUL_P_W-1:0]  addend;
  logic                                step, neg;

  assign step   = busy_q && (cnt_q != '0);
  // two's complement multiplier: the top bit carries negative weight
  assign neg    = bsig_q && (cnt_q == pdc_pkg::MUL_CNT_W'(1));
  assign addend = b_sh_q[0] ? a_sh_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.nbits;
    end else if (step) begin
      cnt_q <= cnt_q - 1'b1;
    end else if (busy_q) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_sh_q <= pdc_pkg::MUL_P_W'(a_i);
      b_sh_q <= b_i;
      bsig_q <= req_i.b_signed;
      acc_q  <= '0;
    end else if (step) begin
      acc_q  <= neg ? (acc_q - addend) : (acc_q + addend);
      a_sh_q <= a_sh_q <<< 1;
      b_sh_q <= b_sh_q >> 1;
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign p_o    = acc_q;

endmodule

[hdl/pid_distance_controller_core.sv]
// PID distance controller core: filtered derivative, conditional-integration anti-windup.
// A safety stop skips the multiplier; otherwise eight serial multiplies run in turn, with a
//   clamp before the last, then the result goes to the output register.
// A new sample is taken only in idle, after the last one is through; all multiplies share one bit-serial multiplier.
// Reset (async, active low) clears controller state and loads register defaults.
// Depends on pdc_pkg, pdc_if, pdc_cfg_regs and pdc_serial_mul.
module pid_distance_controller_core #(
  parameter int DIST_BITS = pdc_pkg::DIST_BITS_DEF,
  parameter int DRIVE_MAX = pdc_pkg::DRIVE_MAX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pdc_in_if.sink                          din_i,
  pdc_out_if.source                       dout_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pdc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pdc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int ERR_W   = DIST_BITS + 1;             // setpoint - distance
  localparam int DIFF_W  = DIST_BITS + 2;             // error - previous error
  localparam int DRAW_W  = DIFF_W + pdc_pkg::RATE_W;  // raw derivative
  localparam int DMAX_W  = $clog2(DRIVE_MAX + 1);
  localparam int DRIVE_W = DMAX_W + 1;
  localparam int ACC_W   = pdc_pkg::ACC_W;
  localparam int SUM_W   = 60;                        // widest partial sum of the control
  localparam int UABS_W  = 25;                        // |u| after clamp, up to 2^24
  localparam int Q24     = 24;

  localparam logic signed [SUM_W-1:0] ACC_MAXV = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] ACC_MINV = ~ACC_MAXV;
  localparam logic signed [SUM_W-1:0] ONE_Q24  = SUM_W'(64'sd1 <<< Q24);
  localparam logic signed [SUM_W-1:0] MONE_Q24 = -ONE_Q24;

  // sequencer codes: idle, one state per multiply, a clamp before the drive multiply, and output
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MDRAW = 4'd1;   // (e - e_prev) * rate
  localparam logic [3:0] S_MFDA  = 4'd2;   // fd * alpha
  localparam logic [3:0] S_MFDB  = 4'd3;   // d_raw * (1 - alpha)
  localparam logic [3:0] S_MIP   = 4'd4;   // e * period
  localparam logic [3:0] S_MP    = 4'd5;   // kp * e
  localparam logic [3:0] S_MI    = 4'd6;   // ki * icand
  localparam logic [3:0] S_MD    = 4'd7;   // kd * fd
  localparam logic [3:0] S_CLAMP = 4'd8;
  localparam logic [3:0] S_MDRV  = 4'd9;   // |u| * DRIVE_MAX
  localparam logic [3:0] S_DONE  = 4'd10;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
    if (x > ACC_MAXV) return ACC_MAXV[ACC_W-1:0];
    if (x < ACC_MINV) return ACC_MINV[ACC_W-1:0];
    return x[ACC_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [DIST_BITS-1:0] setpoint, threshold;
  pdc_pkg::cfg_t        cfg;

  pdc_cfg_regs #(
    .DIST_BITS (DIST_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .setpoint_o  (setpoint),
    .threshold_o (threshold),
    .cfg_o       (cfg)
  );

  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // Shared serial multiplier
  // ---------------------------------------------------------------------------
  pdc_pkg::mul_req_t                   mul_req;
  logic signed [pdc_pkg::MUL_A_W-1:0]  mul_a;
  logic [pdc_pkg::MUL_B_W-1:0]         mul_b;
  logic                                mul_done;
  logic signed [pdc_pkg::MUL_P_W-1:0]  mul_p, p_sh8, p_sh16;

  pdc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign p_sh8  = mul_p >>> 8;
  assign p_sh16 = mul_p >>> 16;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [3:0]                state_q;
  logic                      iss_q;     // issue the multiply of the current state
  logic                      ov_q;      // output transaction pending

  // controller state
  logic signed [ERR_W-1:0]   prev_q;
  logic signed [ACC_W-1:0]   isum_q, fd_q;

  // per-sample working registers
  logic signed [ERR_W-1:0]   err_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [DRAW_W-1:0]  draw_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [ACC_W-1:0]   icand_q;
  logic [UABS_W-1:0]         uabs_q;
  logic                      uneg_q, sat_q;
  logic signed [DRIVE_W-1:0] res_drive_q, out_drive_q;
  logic                      res_stop_q, res_sat_q, out_stop_q, out_sat_q;

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  logic                      accept, too_close;
  logic signed [ERR_W-1:0]   err_d;
  logic signed [DIFF_W-1:0]  diff_d;

  assign din_i.ready = (state_q == S_IDLE);
  assign accept      = din_i.valid && din_i.ready;
  assign too_close   = din_i.distance < threshold;
  assign err_d       = $signed({1'b0, setpoint}) - $signed({1'b0, din_i.distance});
  assign diff_d      = DIFF_W'(err_d) - DIFF_W'(prev_q);

  // ---------------------------------------------------------------------------
  // Operand select: multiplicand in parallel, multiplier shifted out LSB first
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_req.start    = iss_q;
    mul_req.b_signed = 1'b1;
    mul_req.nbits    = pdc_pkg::MUL_CNT_W'(pdc_pkg::MUL_B_W);
    mul_a            = '0;
    mul_b            = '0;
    case (state_q)
      S_MDRAW: begin
        mul_a         = pdc_pkg::MUL_A_W'(cfg.rate);
        mul_b         = pdc_pkg::MUL_B_W'(diff_q);
        mul_req.nbits = pdc_pkg::MUL_CNT_W'(DIFF_W);
      end
      S_MFDA: begin
        mul_a            = fd_q;
        mul_b            = pdc_pkg::MUL_B_W'(cfg.alpha);
        mul_req.b_signed = 1'b0;
        mul_req.nbits    = pdc_pkg::MUL_CNT_W'(pdc_pkg::ALPHA_W);
      end
      S_MFDB: begin
        mul_a            = pdc_pkg::MUL_A_W'(draw_q);
        mul_b            = pdc_pkg::MUL_B_W'(pdc_pkg::ALPHA_ONE - cfg.alpha);
        mul_req.b_signed = 1'b0;
        mul_req.nbits    = pdc_pkg::MUL_CNT_W'(pdc_pkg::ALPHA_W);
      end
      S_MIP: begin
        mul_a         = pdc_pkg::MUL_A_W'(cfg.period);
        mul_b         = pdc_pkg::MUL_B_W'(err_q);
        mul_req.nbits = pdc_pkg::MUL_CNT_W'(ERR_W);
      end
      S_MP: begin
        mul_a         = pdc_pkg::MUL_A_W'(cfg.gain_p);
        mul_b         = pdc_pkg::MUL_B_W'(err_q);
        mul_req.nbits = pdc_pkg::MUL_CNT_W'(ERR_W);
      end
      S_MI: begin
        mul_a = icand_q;
        mul_b = cfg.gain_i;
      end
      S_MD: begin
        mul_a = fd_q;
        mul_b = cfg.gain_d;
      end
      S_MDRV: begin
        mul_a            = pdc_pkg::MUL_A_W'(uabs_q);
        mul_b            = pdc_pkg::MUL_B_W'(DRIVE_MAX);
        mul_req.b_signed = 1'b0;
        mul_req.nbits    = pdc_pkg::MUL_CNT_W'(DMAX_W);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Clamp, anti-windup and drive
  // ---------------------------------------------------------------------------
  logic               u_hi, u_lo, keep, err_neg, err_pos;
  logic [SUM_W-1:0]   u_abs;
  logic [DMAX_W-1:0]  mag;
  logic signed [DRIVE_W-1:0] mag_s, drive_d;

  assign u_hi    = sum_q > ONE_Q24;
  assign u_lo    = sum_q < MONE_Q24;
  assign err_neg = err_q[ERR_W-1];
  assign err_pos = !err_q[ERR_W-1] && (err_q != '0);
  // integrate only when unsaturated or when the error pulls back from the rail
  assign keep    = (!u_hi && !u_lo) || (u_hi && err_neg) || (u_lo && err_pos);
  assign u_abs   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  assign mag     = mul_p[Q24 +: DMAX_W];
  assign mag_s   = $signed({1'b0, mag});
  // drive is the negated control, truncated toward zero
  assign drive_d = uneg_q ? mag_s : -mag_s;

  // ---------------------------------------------------------------------------
  // Sequencer and controller state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iss_q   <= 1'b0;
      ov_q    <= 1'b0;
      prev_q  <= '0;
      isum_q  <= '0;
      fd_q    <= '0;
    end else begin
      iss_q <= 1'b0;
      if (dout_o.ready) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (too_close) begin
              prev_q  <= '0;
              isum_q  <= '0;
              fd_q    <= '0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_MDRAW;
              iss_q   <= 1'b1;
            end
          end
        end
        S_MDRAW, S_MFDA, S_MIP, S_MP, S_MI: begin
          if (mul_done) begin
            state_q <= state_q + 4'd1;
            iss_q   <= 1'b1;
          end
        end
        S_MFDB: begin
          if (mul_done) begin
            fd_q    <= sat_acc(sum_q + mul_p[SUM_W-1:0]);
            state_q <= S_MIP;
            iss_q   <= 1'b1;
          end
        end
        S_MD: begin
          if (mul_done) state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          if (keep) isum_q <= icand_q;
          prev_q  <= err_q;
          state_q <= S_MDRV;
          iss_q   <= 1'b1;
        end
        S_MDRV: begin
          if (mul_done) state_q <= S_DONE;
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!ov_q || dout_o.ready) begin
            ov_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          err_q       <= err_d;
          diff_q      <= diff_d;
          res_drive_q <= '0;
          res_stop_q  <= 1'b1;
          res_sat_q   <= 1'b0;
        end
      end
      S_MDRAW: if (mul_done) draw_q <= mul_p[DRAW_W-1:0];
      S_MFDA:  if (mul_done) sum_q <= p_sh16[SUM_W-1:0];
      S_MIP:   if (mul_done) icand_q <= sat_acc(SUM_W'(isum_q) + p_sh8[SUM_W-1:0]);
      S_MP:    if (mul_done) sum_q <= mul_p[SUM_W-1:0];
      S_MI:    if (mul_done) sum_q <= sum_q + p_sh16[SUM_W-1:0];
      S_MD:    if (mul_done) sum_q <= sum_q + p_sh16[SUM_W-1:0];
      S_CLAMP: begin
        sat_q  <= u_hi || u_lo;
        uneg_q <= sum_q[SUM_W-1];
        uabs_q <= (u_hi || u_lo) ? ONE_Q24[UABS_W-1:0] : u_abs[UABS_W-1:0];
      end
      S_MDRV: begin
        if (mul_done) begin
          res_drive_q <= drive_d;
          res_stop_q  <= 1'b0;
          res_sat_q   <= sat_q;
        end
      end
      S_DONE: begin
        if (!ov_q || dout_o.ready) begin
          out_drive_q <= res_drive_q;
          out_stop_q  <= res_stop_q;
          out_sat_q   <= res_sat_q;
        end
      end
      default: ;
    endcase
  end

  assign dout_o.valid       = ov_q;
  assign dout_o.drive       = out_drive_q;
  assign dout_o.safety_stop = out_stop_q;
  assign dout_o.saturated   = out_sat_q;

endmodule
